/* rtl/tlc_pkg.sv */
// ----------------------------------------------------------------------------
// tlc_pkg: shared definitions for the two-way traffic light controller
// Register indexes, reset values, phase and lamp codes, the struct that
// carries configuration between modules, and the controller state struct.
// ----------------------------------------------------------------------------
package tlc_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // Register indexes (byte address is four times the index).
  localparam logic [2:0] REG_GREEN_PERIOD  = 3'd0;
  localparam logic [2:0] REG_AMBER_LONG    = 3'd1;
  localparam logic [2:0] REG_AMBER_SHORT   = 3'd2;
  localparam logic [2:0] REG_ALL_RED_LONG  = 3'd3;
  localparam logic [2:0] REG_ALL_RED_SHORT = 3'd4;
  localparam logic [2:0] REG_RED_AMBER     = 3'd5;
  localparam logic [2:0] REG_LEAST_GREEN   = 3'd6;

  localparam logic [7:0] RST_GREEN_PERIOD  = 8'd20;
  localparam logic [7:0] RST_AMBER_LONG    = 8'd4;
  localparam logic [7:0] RST_AMBER_SHORT   = 8'd1;
  localparam logic [7:0] RST_ALL_RED_LONG  = 8'd2;
  localparam logic [7:0] RST_ALL_RED_SHORT = 8'd1;
  localparam logic [7:0] RST_RED_AMBER     = 8'd1;
  localparam logic [7:0] RST_LEAST_GREEN   = 8'd1;

  // Phases of a swap.
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_AMBER    = 3'd1;
  localparam logic [2:0] PH_ALLRED   = 3'd2;
  localparam logic [2:0] PH_REDAMBER = 3'd3;
  localparam logic [2:0] PH_LEAST    = 3'd4;

  // Lamp codes.
  localparam logic [2:0] LAMP_RED       = 3'd1;
  localparam logic [2:0] LAMP_AMBER     = 3'd2;
  localparam logic [2:0] LAMP_RED_AMBER = 3'd3;
  localparam logic [2:0] LAMP_GREEN     = 3'd4;

  typedef struct packed {
    logic [7:0] green_period;
    logic [7:0] amber_long;
    logic [7:0] amber_short;
    logic [7:0] all_red_long;
    logic [7:0] all_red_short;
    logic [7:0] red_amber_time;
    logic [7:0] least_green;
  } cfg_t;

  typedef struct packed {
    logic       west_has_green;
    logic [2:0] phase;
    logic [7:0] phase_count;
    logic       long_swap;
    logic [7:0] period_count;
    logic       west_waiting;
    logic       south_waiting;
    logic       led_on;
  } state_t;

endpackage

/* rtl/two_way_traffic_light_controller.sv */
// ----------------------------------------------------------------------------
// two_way_traffic_light_controller: west/south junction controller
// One request per time slot carries the tick and both buttons; each request
// updates the swap sequencer and yields one result with both lamp codes and
// the request LED.
//
//   Channel  Handshake             Payload
//   input    in_valid / in_ready   tick, west_press, south_press
//   output   out_valid / out_ready south_lamp, west_lamp, request_led
//   config   APB psel/penable      paddr, pwdata, prdata
//
// The state update and lamp decode sit between the state registers and the
// result register, so a request is taken every cycle while the result
// register is empty or being emptied.
// Synchronous reset restores the default timings and west green, idle.
// A stalled result holds the result register and stops new requests.
// ----------------------------------------------------------------------------
module two_way_traffic_light_controller (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        tick,
  input  logic                        west_press,
  input  logic                        south_press,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  south_lamp,
  output logic [2:0]                  west_lamp,
  output logic                        request_led,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tlc_pkg::ADDR_W-1:0]  paddr,
  input  logic [tlc_pkg::DATA_W-1:0]  pwdata,
  output logic [tlc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  tlc_pkg::cfg_t   cfg;
  tlc_pkg::state_t state;
  tlc_pkg::state_t state_next;
  logic [2:0]      south_lamp_next;
  logic [2:0]      west_lamp_next;
  logic            accept;

  tlc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Walks through every phase whose count has run out; at most four
  // phases can be passed in one request.
  function automatic tlc_pkg::state_t settle(tlc_pkg::state_t s, tlc_pkg::cfg_t c);
    tlc_pkg::state_t r;
    r = s;
    for (int i = 0; i < 4; i++) begin
      if (r.phase != tlc_pkg::PH_IDLE && r.phase_count == 8'd0) begin
        case (r.phase)
          tlc_pkg::PH_AMBER: begin
            r.phase       = tlc_pkg::PH_ALLRED;
            r.phase_count = r.long_swap ? c.all_red_long : c.all_red_short;
          end
          tlc_pkg::PH_ALLRED: begin
            r.phase          = tlc_pkg::PH_REDAMBER;
            r.west_has_green = !r.west_has_green;
            r.phase_count    = c.red_amber_time;
          end
          tlc_pkg::PH_REDAMBER: begin
            r.phase       = tlc_pkg::PH_LEAST;
            r.phase_count = c.least_green;
          end
          default: begin
            // The newly green direction has been served.
            if (r.west_has_green) begin
              r.west_waiting = 1'b0;
              if (!r.south_waiting) r.led_on = 1'b0;
            end else begin
              r.south_waiting = 1'b0;
              if (!r.west_waiting) r.led_on = 1'b0;
            end
            r.phase       = tlc_pkg::PH_IDLE;
            r.phase_count = 8'd0;
          end
        endcase
      end
    end
    return r;
  endfunction

  function automatic tlc_pkg::state_t start_swap(tlc_pkg::state_t s, tlc_pkg::cfg_t c,
                                                 logic is_long);
    tlc_pkg::state_t r;
    r             = s;
    r.long_swap   = is_long;
    r.phase       = tlc_pkg::PH_AMBER;
    r.phase_count = is_long ? c.amber_long : c.amber_short;
    return settle(r, c);
  endfunction

  always_comb begin
    tlc_pkg::state_t s;
    logic            timer_event;
    logic [2:0]      go_lamp;
    s           = state;
    timer_event = 1'b0;

    if (tick) begin
      if (s.period_count <= 8'd1) begin
        timer_event    = 1'b1;
        s.period_count = cfg.green_period;
      end else begin
        s.period_count = s.period_count - 8'd1;
      end
    end
    if (west_press) begin
      s.west_waiting = 1'b1;
      s.led_on       = 1'b1;
    end
    if (south_press) begin
      s.south_waiting = 1'b1;
      s.led_on        = 1'b1;
    end
    if (west_press || south_press) begin
      s.period_count = cfg.green_period;
      timer_event    = 1'b1;
    end

    if (s.phase != tlc_pkg::PH_IDLE) begin
      // Timer events are dropped while a swap is running.
      if (tick) begin
        if (s.phase_count != 8'd0) s.phase_count = s.phase_count - 8'd1;
        s = settle(s, cfg);
      end
    end else if (s.west_waiting && !s.south_waiting) begin
      if (s.west_has_green) begin
        s.west_waiting = 1'b0;
        s.led_on       = 1'b0;
      end else begin
        s = start_swap(s, cfg, 1'b0);
      end
    end else if (s.south_waiting && !s.west_waiting) begin
      if (!s.west_has_green) begin
        s.south_waiting = 1'b0;
        s.led_on        = 1'b0;
      end else begin
        s = start_swap(s, cfg, 1'b0);
      end
    end else if (timer_event) begin
      s = start_swap(s, cfg, 1'b1);
    end

    case (s.phase)
      tlc_pkg::PH_AMBER:    go_lamp = tlc_pkg::LAMP_AMBER;
      tlc_pkg::PH_ALLRED:   go_lamp = tlc_pkg::LAMP_RED;
      tlc_pkg::PH_REDAMBER: go_lamp = tlc_pkg::LAMP_RED_AMBER;
      default:              go_lamp = tlc_pkg::LAMP_GREEN;
    endcase

    state_next      = s;
    south_lamp_next = s.west_has_green ? tlc_pkg::LAMP_RED : go_lamp;
    west_lamp_next  = s.west_has_green ? go_lamp : tlc_pkg::LAMP_RED;
  end

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state.west_has_green <= 1'b1;
      state.phase          <= tlc_pkg::PH_IDLE;
      state.phase_count    <= 8'd0;
      state.long_swap      <= 1'b0;
      state.period_count   <= tlc_pkg::RST_GREEN_PERIOD;
      state.west_waiting   <= 1'b0;
      state.south_waiting  <= 1'b0;
      state.led_on         <= 1'b0;
      out_valid            <= 1'b0;
    end else begin
      if (accept) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      south_lamp  <= south_lamp_next;
      west_lamp   <= west_lamp_next;
      request_led <= state_next.led_on;
    end
  end

endmodule

/* rtl/tlc_cfg.sv */
// ----------------------------------------------------------------------------
// tlc_cfg: configuration register file
// APB-style slave holding the seven timing registers, with read-back.
// ----------------------------------------------------------------------------
module tlc_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tlc_pkg::ADDR_W-1:0]  paddr,
  input  logic [tlc_pkg::DATA_W-1:0]  pwdata,
  output logic [tlc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output tlc_pkg::cfg_t               cfg
);

  logic [2:0] index;
  logic       wr_en;
  logic [7:0] rd_byte;

  assign index  = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.green_period   <= tlc_pkg::RST_GREEN_PERIOD;
      cfg.amber_long     <= tlc_pkg::RST_AMBER_LONG;
      cfg.amber_short    <= tlc_pkg::RST_AMBER_SHORT;
      cfg.all_red_long   <= tlc_pkg::RST_ALL_RED_LONG;
      cfg.all_red_short  <= tlc_pkg::RST_ALL_RED_SHORT;
      cfg.red_amber_time <= tlc_pkg::RST_RED_AMBER;
      cfg.least_green    <= tlc_pkg::RST_LEAST_GREEN;
    end else if (wr_en) begin
      case (index)
        tlc_pkg::REG_GREEN_PERIOD:  cfg.green_period   <= pwdata[7:0];
        tlc_pkg::REG_AMBER_LONG:    cfg.amber_long     <= pwdata[7:0];
        tlc_pkg::REG_AMBER_SHORT:   cfg.amber_short    <= pwdata[7:0];
        tlc_pkg::REG_ALL_RED_LONG:  cfg.all_red_long   <= pwdata[7:0];
        tlc_pkg::REG_ALL_RED_SHORT: cfg.all_red_short  <= pwdata[7:0];
        tlc_pkg::REG_RED_AMBER:     cfg.red_amber_time <= pwdata[7:0];
        tlc_pkg::REG_LEAST_GREEN:   cfg.least_green    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      tlc_pkg::REG_GREEN_PERIOD:  rd_byte = cfg.green_period;
      tlc_pkg::REG_AMBER_LONG:    rd_byte = cfg.amber_long;
      tlc_pkg::REG_AMBER_SHORT:   rd_byte = cfg.amber_short;
      tlc_pkg::REG_ALL_RED_LONG:  rd_byte = cfg.all_red_long;
      tlc_pkg::REG_ALL_RED_SHORT: rd_byte = cfg.all_red_short;
      tlc_pkg::REG_RED_AMBER:     rd_byte = cfg.red_amber_time;
      tlc_pkg::REG_LEAST_GREEN:   rd_byte = cfg.least_green;
      default:                    rd_byte = 8'd0;
    endcase
  end

  assign prdata = {{(tlc_pkg::DATA_W-8){1'b0}}, rd_byte};

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the two-way traffic light controller
// Time slot requests (tick plus both buttons) are queued and sent with random
// gaps while the result side stalls at random. A cycle-level predictor of the
// swap sequencer follows every accepted request, and each result is checked
// against the oldest prediction. Timings are rewritten over the APB port
// between phases, once the junction has drained.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_SLOTS = 160;

  typedef struct packed {
    logic tick;
    logic west_press;
    logic south_press;
  } slot_t;

  typedef struct packed {
    logic [2:0] south_lamp;
    logic [2:0] west_lamp;
    logic       request_led;
  } lamps_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       tick = 1'b0;
  logic                       west_press = 1'b0;
  logic                       south_press = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [2:0]                 south_lamp;
  logic [2:0]                 west_lamp;
  logic                       request_led;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [tlc_pkg::ADDR_W-1:0] paddr = '0;
  logic [tlc_pkg::DATA_W-1:0] pwdata = '0;
  logic [tlc_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  two_way_traffic_light_controller dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .tick        (tick),
    .west_press  (west_press),
    .south_press (south_press),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .south_lamp  (south_lamp),
    .west_lamp   (west_lamp),
    .request_led (request_led),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state and the timings it believes are loaded.
  tlc_pkg::cfg_t timing;
  logic          west_green;
  logic [2:0]    swap_phase;
  logic [7:0]    phase_left;
  logic          long_swap_on;
  logic [7:0]    period_left;
  logic          west_req;
  logic          south_req;
  logic          led_lit;

  slot_t  slot_queue[$];
  lamps_t lamps_due[$];
  int     slots_queued = 0;
  int     slots_taken = 0;
  int     fail_count = 0;
  int     quiet_cycles = 0;
  logic   req_taken = 1'b0;

  slot_t  next_slot;
  int     send_gap = 0;
  logic   send_steady = 1'b0;
  int     stall_left = 0;
  logic   take_steady = 1'b0;
  lamps_t want;

  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Walks through every phase whose count has run out; zero-length phases
  // are passed in the same request.
  task automatic settle_swap();
    while (swap_phase != tlc_pkg::PH_IDLE && phase_left == 8'd0) begin
      case (swap_phase)
        tlc_pkg::PH_AMBER: begin
          swap_phase = tlc_pkg::PH_ALLRED;
          phase_left = long_swap_on ? timing.all_red_long : timing.all_red_short;
        end
        tlc_pkg::PH_ALLRED: begin
          swap_phase = tlc_pkg::PH_REDAMBER;
          west_green = !west_green;
          phase_left = timing.red_amber_time;
        end
        tlc_pkg::PH_REDAMBER: begin
          swap_phase = tlc_pkg::PH_LEAST;
          phase_left = timing.least_green;
        end
        default: begin
          if (west_green) begin
            west_req = 1'b0;
            if (!south_req) led_lit = 1'b0;
          end else begin
            south_req = 1'b0;
            if (!west_req) led_lit = 1'b0;
          end
          swap_phase = tlc_pkg::PH_IDLE;
          phase_left = 8'd0;
        end
      endcase
    end
  endtask

  task automatic begin_swap(input logic is_long);
    long_swap_on = is_long;
    swap_phase = tlc_pkg::PH_AMBER;
    phase_left = is_long ? timing.amber_long : timing.amber_short;
    settle_swap();
  endtask

  task automatic advance_junction(input slot_t s, output lamps_t r);
    logic       timer_evt;
    logic [2:0] green_code;
    timer_evt = 1'b0;
    if (s.tick) begin
      if (period_left <= 8'd1) begin
        timer_evt = 1'b1;
        period_left = timing.green_period;
      end else begin
        period_left = period_left - 8'd1;
      end
    end
    if (s.west_press) begin
      west_req = 1'b1;
      led_lit = 1'b1;
    end
    if (s.south_press) begin
      south_req = 1'b1;
      led_lit = 1'b1;
    end
    if (s.west_press || s.south_press) begin
      period_left = timing.green_period;
      timer_evt = 1'b1;
    end

    if (swap_phase != tlc_pkg::PH_IDLE) begin
      if (s.tick) begin
        if (phase_left > 8'd0) phase_left = phase_left - 8'd1;
        settle_swap();
      end
    end else if (west_req && !south_req) begin
      if (west_green) begin
        west_req = 1'b0;
        led_lit = 1'b0;
      end else begin
        begin_swap(1'b0);
      end
    end else if (south_req && !west_req) begin
      if (!west_green) begin
        south_req = 1'b0;
        led_lit = 1'b0;
      end else begin
        begin_swap(1'b0);
      end
    end else if (timer_evt) begin
      begin_swap(1'b1);
    end

    case (swap_phase)
      tlc_pkg::PH_AMBER:    green_code = tlc_pkg::LAMP_AMBER;
      tlc_pkg::PH_ALLRED:   green_code = tlc_pkg::LAMP_RED;
      tlc_pkg::PH_REDAMBER: green_code = tlc_pkg::LAMP_RED_AMBER;
      default:              green_code = tlc_pkg::LAMP_GREEN;
    endcase
    r.west_lamp = west_green ? green_code : tlc_pkg::LAMP_RED;
    r.south_lamp = west_green ? tlc_pkg::LAMP_RED : green_code;
    r.request_led = led_lit;
  endtask

  // Sender: a fresh request is offered only once the previous one was taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if ($urandom_range(0, 99) < 3) send_steady = !send_steady;
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        in_valid <= 1'b0;
      end else if (slot_queue.size() > 0) begin
        next_slot = slot_queue.pop_front();
        tick <= next_slot.tick;
        west_press <= next_slot.west_press;
        south_press <= next_slot.south_press;
        in_valid <= 1'b1;
        send_gap = send_steady ? 0 : idle_span();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) < 3) take_steady = !take_steady;
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!take_steady && $urandom_range(0, 99) < 30) stall_left = idle_span();
      end
    end
  end

  // Results are checked before this edge's request is predicted; a result can
  // never belong to a request taken at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (lamps_due.size() == 0) begin
          fail_count++;
          $error("result with no request outstanding: south_lamp %0d west_lamp %0d led %0d",
                 south_lamp, west_lamp, request_led);
        end else begin
          want = lamps_due.pop_front();
          if (south_lamp !== want.south_lamp) begin
            fail_count++;
            $error("south_lamp: expected %0d, got %0d", want.south_lamp, south_lamp);
          end
          if (west_lamp !== want.west_lamp) begin
            fail_count++;
            $error("west_lamp: expected %0d, got %0d", want.west_lamp, west_lamp);
          end
          if (request_led !== want.request_led) begin
            fail_count++;
            $error("request_led: expected %0d, got %0d", want.request_led, request_led);
          end
        end
      end
      if (in_valid && in_ready) begin
        advance_junction('{tick: tick, west_press: west_press, south_press: south_press},
                         want);
        lamps_due.push_back(want);
        slots_taken++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic queue_slot(input logic tk, input logic wp, input logic sp);
    slot_queue.push_back('{tick: tk, west_press: wp, south_press: sp});
    slots_queued++;
  endtask

  task automatic make_traffic(input int n, input int tick_pct, input int press_pct);
    for (int i = 0; i < n; i++) begin
      queue_slot($urandom_range(0, 99) < tick_pct, $urandom_range(0, 99) < press_pct,
                 $urandom_range(0, 99) < press_pct);
    end
  endtask

  // Returns once every queued request has been taken and answered.
  task automatic wait_drained();
    while (slots_taken != slots_queued || lamps_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      tlc_pkg::REG_GREEN_PERIOD:  timing.green_period = val;
      tlc_pkg::REG_AMBER_LONG:    timing.amber_long = val;
      tlc_pkg::REG_AMBER_SHORT:   timing.amber_short = val;
      tlc_pkg::REG_ALL_RED_LONG:  timing.all_red_long = val;
      tlc_pkg::REG_ALL_RED_SHORT: timing.all_red_short = val;
      tlc_pkg::REG_RED_AMBER:     timing.red_amber_time = val;
      tlc_pkg::REG_LEAST_GREEN:   timing.least_green = val;
      default: ;
    endcase
  endtask

  task automatic load_timings(input tlc_pkg::cfg_t t);
    write_reg(tlc_pkg::REG_GREEN_PERIOD, t.green_period);
    write_reg(tlc_pkg::REG_AMBER_LONG, t.amber_long);
    write_reg(tlc_pkg::REG_AMBER_SHORT, t.amber_short);
    write_reg(tlc_pkg::REG_ALL_RED_LONG, t.all_red_long);
    write_reg(tlc_pkg::REG_ALL_RED_SHORT, t.all_red_short);
    write_reg(tlc_pkg::REG_RED_AMBER, t.red_amber_time);
    write_reg(tlc_pkg::REG_LEAST_GREEN, t.least_green);
  endtask

  initial begin
    tlc_pkg::cfg_t plan;
    int            press_pct;
    timing = {tlc_pkg::RST_GREEN_PERIOD, tlc_pkg::RST_AMBER_LONG, tlc_pkg::RST_AMBER_SHORT,
              tlc_pkg::RST_ALL_RED_LONG, tlc_pkg::RST_ALL_RED_SHORT, tlc_pkg::RST_RED_AMBER,
              tlc_pkg::RST_LEAST_GREEN};
    west_green = 1'b1;
    swap_phase = tlc_pkg::PH_IDLE;
    phase_left = 8'd0;
    long_swap_on = 1'b0;
    period_left = tlc_pkg::RST_GREEN_PERIOD;
    west_req = 1'b0;
    south_req = 1'b0;
    led_lit = 1'b0;

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Short timer and a zero short all-red and least-green so that the opening
    // sequence reaches expiries and skipped phases quickly.
    load_timings({8'd3, 8'd2, 8'd1, 8'd1, 8'd0, 8'd1, 8'd0});
    queue_slot(1'b0, 1'b0, 1'b0);
    queue_slot(1'b0, 1'b1, 1'b0);  // west already green: cleared at once
    queue_slot(1'b0, 1'b0, 1'b1);  // lone south request: short swap
    queue_slot(1'b0, 1'b0, 1'b0);  // no tick, transition holds
    queue_slot(1'b1, 1'b0, 1'b1);  // press for the direction being served
    queue_slot(1'b1, 1'b1, 1'b0);  // swap ends here, west waits
    queue_slot(1'b0, 1'b0, 1'b0);  // lone west request swaps back
    queue_slot(1'b1, 1'b0, 1'b0);
    queue_slot(1'b1, 1'b0, 1'b0);
    queue_slot(1'b1, 1'b0, 1'b0);
    queue_slot(1'b0, 1'b1, 1'b1);  // both pressed while a timer-started long swap runs
    for (int i = 0; i < 8; i++) queue_slot(1'b1, 1'b0, 1'b0);
    queue_slot(1'b1, 1'b1, 1'b1);
    for (int i = 0; i < 5; i++) queue_slot(1'b1, 1'b0, 1'b0);
    make_traffic(PHASE_SLOTS, 70, 8);
    wait_drained();

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: plan = {tlc_pkg::RST_GREEN_PERIOD, tlc_pkg::RST_AMBER_LONG,
                   tlc_pkg::RST_AMBER_SHORT, tlc_pkg::RST_ALL_RED_LONG,
                   tlc_pkg::RST_ALL_RED_SHORT, tlc_pkg::RST_RED_AMBER,
                   tlc_pkg::RST_LEAST_GREEN};
        1: plan = {8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
        2: plan = '1;
        3: plan = {8'd0, 8'd2, 8'd0, 8'd1, 8'd0, 8'd0, 8'd2};  // zero period acts as one
        default: begin
          plan.green_period = 8'($urandom_range(1, 10));
          plan.amber_long = 8'($urandom_range(0, 3));
          plan.amber_short = 8'($urandom_range(0, 3));
          plan.all_red_long = 8'($urandom_range(0, 3));
          plan.all_red_short = 8'($urandom_range(0, 3));
          plan.red_amber_time = 8'($urandom_range(0, 3));
          plan.least_green = 8'($urandom_range(0, 3));
        end
      endcase
      load_timings(plan);
      press_pct = (p % 3 == 2) ? 35 : $urandom_range(2, 12);
      make_traffic(PHASE_SLOTS, (p == 2) ? 95 : $urandom_range(30, 95), press_pct);
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
